// ===== design/fmpd_pkg.sv =====
// Shared types, defaults and the CORDIC arctangent table for the FM phase discriminator.
package fmpd_pkg;

  localparam int SampleWidthDef = 16;
  localparam int PhaseWidthDef  = 16;
  localparam int AngleWidth     = 32;
  localparam int AtanSteps      = 32;

  typedef logic [AngleWidth-1:0] angle_t;

  // atan(2^-i) in units where 2^32 is one full turn
  localparam angle_t AtanTurns [AtanSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFinish
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_step;
    logic emit;
  } status_t;

endpackage

// ===== design/fmpd_ctrl.sv =====
// Controller state machine: sequences load, CORDIC steps and result commit.
module fmpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  fmpd_pkg::status_t status_i,
  output fmpd_pkg::cmd_t    cmd_o
);
  import fmpd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    // drop the held result once taken
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!status_i.emit) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/fmpd_datapath.sv =====
// Datapath: CORDIC vectoring lanes, angle accumulator, phase history and result register.
module fmpd_datapath #(
  parameter int SAMPLE_WIDTH = fmpd_pkg::SampleWidthDef,
  parameter int PHASE_WIDTH  = fmpd_pkg::PhaseWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phase_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quadrature_i,
  input  logic                           block_start_i,
  input  fmpd_pkg::cmd_t                 cmd_i,
  output fmpd_pkg::status_t              status_o,
  output logic signed [PHASE_WIDTH-1:0]  freq_estimate_o
);
  import fmpd_pkg::*;

  // three guard bits cover negation and the CORDIC gain
  localparam int LaneWidth = SAMPLE_WIDTH + 3;
  localparam int CntWidth  = $clog2(PHASE_WIDTH);
  localparam int Drop      = AngleWidth - PHASE_WIDTH;
  localparam angle_t Half  = (angle_t'(1) << Drop) >> 1;

  logic signed [LaneWidth-1:0] x_q, x_d, y_q, y_d;
  logic signed [LaneWidth-1:0] x_in, y_in, dx, dy;
  angle_t                      z_q, z_d, z_round, atan_step;
  logic [CntWidth-1:0]         cnt_q, cnt_d;
  logic                        zero_q, start_q;
  logic [PHASE_WIDTH-1:0]      prev_q, phase, freq_q;
  logic                        have_prev_q;

  assign x_in = LaneWidth'(in_phase_i);
  assign y_in = LaneWidth'(quadrature_i);

  assign dx        = x_q >>> cnt_q;
  assign dy        = y_q >>> cnt_q;
  assign atan_step = AtanTurns[5'(cnt_q)];

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
      if (x_in[LaneWidth-1]) begin
        // left half plane: negate and start from a half turn
        x_d = -x_in;
        y_d = -y_in;
        z_d = angle_t'(1) << (AngleWidth - 1);
      end else begin
        x_d = x_in;
        y_d = y_in;
        z_d = '0;
      end
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + CntWidth'(1);
      if (!y_q[LaneWidth-1]) begin
        x_d = x_q + dy;
        y_d = y_q - dx;
        z_d = z_q + atan_step;
      end else begin
        x_d = x_q - dy;
        y_d = y_q + dx;
        z_d = z_q - atan_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    cnt_q <= cnt_d;
    if (cmd_i.load) begin
      zero_q  <= (in_phase_i == '0) && (quadrature_i == '0);
      start_q <= block_start_i;
    end
  end

  // round to the phase width; a zero sample has phase zero
  assign z_round = z_q + Half;
  assign phase   = zero_q ? '0 : z_round[AngleWidth-1 -: PHASE_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (cmd_i.commit) begin
      prev_q      <= phase;
      have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && status_o.emit) begin
      freq_q <= phase - prev_q;
    end
  end

  assign status_o.last_step = (cnt_q == CntWidth'(PHASE_WIDTH - 1));
  assign status_o.emit      = have_prev_q && !start_q;
  assign freq_estimate_o    = freq_q;

endmodule

// ===== design/fm_phase_discriminator.sv =====
// Top level of the FM phase discriminator: controller and datapath.
//
// Each accepted item is one complex sample (in_phase, quadrature). Its phase is
// found by a four-quadrant CORDIC arctangent (left-half-plane samples are
// negated and start from a half turn, a zero sample has phase zero), and the
// result is the phase step from the previous sample, wrapped in two's
// complement with pi equal to 2^(PHASE_WIDTH-1). An item with block_start set,
// and the first item after reset, only records its phase and gives no result,
// so a block of N samples yields N-1 results. Each item has a load step, one
// shared CORDIC iteration per phase bit, and a final step to round, difference
// and commit. Items are processed one at a time; a finished result waits in
// the output register, so the next item is taken and worked on while it
// waits, and the commit cycle holds only if the previous result has not yet
// been taken.
module fm_phase_discriminator #(
  parameter int SAMPLE_WIDTH = fmpd_pkg::SampleWidthDef,
  parameter int PHASE_WIDTH  = fmpd_pkg::PhaseWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phase_i,
  input  logic signed [SAMPLE_WIDTH-1:0] quadrature_i,
  input  logic                           block_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [PHASE_WIDTH-1:0]  freq_estimate_o
);
  import fmpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequence load, iterate and commit
  fmpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // CORDIC lanes, phase history and the held result
  fmpd_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_phase_i      (in_phase_i),
    .quadrature_i    (quadrature_i),
    .block_start_i   (block_start_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .freq_estimate_o (freq_estimate_o)
  );

endmodule
